// ===== design/sitda_pkg.sv =====
// Shared constants and types for the signed integer to decimal ASCII converter.
package sitda_pkg;

    localparam int DATA_W     = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef logic [DATA_W-1:0] t_mag;
    typedef logic [BCD_W-1:0]  t_bcd;
    typedef logic [IDX_W-1:0]  t_idx;

endpackage

// ===== design/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
// Usage:
//   Drive i_value and raise start while busy is low; the value is taken at
//   that clock edge and busy rises on the next cycle.
//   The magnitude is converted to BCD by a shift-and-add-3 unit, one bit per
//   cycle through the 32 bits, then the S_LEAD state finds the leading digit.
//   Characters then leave one per cycle on o_char_code, each marked by a
//   one-cycle o_valid strobe: '-' first for negative values, then the digits
//   most significant first with no leading zeros. o_last_char marks the
//   final character of the transaction.
//   The first character follows the 32-step conversion loop and S_LEAD:
//   the minus sign is strobed from S_LEAD for a negative value, the digits
//   from S_DIGIT, so a transaction grows with the number of digits. A new
//   start is taken in the cycle the last character is strobed.
//   The receiver cannot stall; every strobed character must be taken.
//   Synchronous active-low reset returns the block to idle with no strobe.
module signed_int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic [31:0] i_value,
    output logic        busy,
    output logic        o_valid,
    output logic [7:0]  o_char_code,
    output logic        o_last_char
);
    import sitda_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_LEAD,
        S_DIGIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    t_idx             r_idx;
    logic             r_valid;
    logic [7:0]       r_char;
    logic             r_last;

    logic load;
    logic step;
    t_mag mag;
    t_bcd bcd;
    t_idx lead;
    logic [3:0] digit;

    assign load = start && (r_state == S_IDLE);
    assign step = (r_state == S_CONV);
    assign mag  = i_value[DATA_W-1] ? (t_mag'(0) - i_value) : i_value;

    sitda_dabble u_dabble (
        .i_clk  (i_clk),
        .i_load (load),
        .i_step (step),
        .i_mag  (mag),
        .o_bcd  (bcd)
    );

    always_comb begin
        lead = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i*4 +: 4] != 4'd0) begin
                lead = t_idx'(i);
            end
        end
    end

    assign digit = bcd[r_idx*4 +: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_neg   <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_char  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_neg   <= i_value[DATA_W-1];
                        r_cnt   <= '0;
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DATA_W - 1)) begin
                        r_state <= S_LEAD;
                    end
                end
                S_LEAD: begin
                    r_idx <= lead;
                    if (r_neg) begin
                        r_valid <= 1'b1;
                        r_char  <= CHAR_MINUS;
                        r_last  <= 1'b0;
                    end
                    r_state <= S_DIGIT;
                end
                S_DIGIT: begin
                    r_valid <= 1'b1;
                    r_char  <= CHAR_ZERO + {4'd0, digit};
                    r_last  <= (r_idx == '0);
                    if (r_idx == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

endmodule

// ===== design/sitda_dabble.sv =====
// Shift-and-add-3 unit: one binary-to-BCD iteration per step.
module sitda_dabble (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_step,
    input  sitda_pkg::t_mag i_mag,
    output sitda_pkg::t_bcd o_bcd
);
    import sitda_pkg::*;

    t_bcd r_bcd;
    t_mag r_bin;
    t_bcd n_adj;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                n_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                n_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bcd <= '0;
            r_bin <= i_mag;
        end else if (i_step) begin
            r_bcd <= {n_adj[BCD_W-2:0], r_bin[DATA_W-1]};
            r_bin <= {r_bin[DATA_W-2:0], 1'b0};
        end
    end

    assign o_bcd = r_bcd;

endmodule
